[design/integer_text_field_parser_unit_defines.svh]
// Assertion macros for the integer text field parser.
`ifndef INTEGER_TEXT_FIELD_PARSER_UNIT_DEFINES_SVH
`define INTEGER_TEXT_FIELD_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define ITFP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("itfp assertion failed");
`define ITFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("itfp assertion failed");
`else
`define ITFP_ASSERT(lbl, prop)
`define ITFP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[design/itfp_pkg.sv]
`default_nettype none

package itfp_pkg;

    localparam int CNT_W = 6;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    localparam logic [1:0] BASE_AUTO = 2'd0;
    localparam logic [1:0] BASE_OCT  = 2'd1;
    localparam logic [1:0] BASE_DEC  = 2'd2;
    localparam logic [1:0] BASE_HEX  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_MATCH = 2'd1;
    localparam logic [1:0] ST_INPUT = 2'd2;

    localparam logic [1:0] BYTES_1 = 2'd0;
    localparam logic [1:0] BYTES_2 = 2'd1;
    localparam logic [1:0] BYTES_4 = 2'd2;
    localparam logic [1:0] BYTES_8 = 2'd3;

    localparam logic [1:0] CFG_BASE_MODE   = 2'd0;
    localparam logic [1:0] CFG_MAX_LEN     = 2'd1;
    localparam logic [1:0] CFG_VALUE_BYTES = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0] char_count;
        logic             sign_taken;
        logic             negative;
        logic             first_zero;
        logic [1:0]       rbase;
        logic             prefix_seen;
        logic             digit_after;
        logic [63:0]      acc;
        logic             overflowed;
    } t_fstate;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] acc;
        logic        negative;
        logic        overflowed;
        logic [4:0]  count;
        logic        returned;
    } t_result;

endpackage

`default_nettype wire

[design/itfp_item_if.sv]
`default_nettype none

interface itfp_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       input_ended;

    modport source (output valid, output char_code, output input_ended, input ready);
    modport sink (input valid, input char_code, input input_ended, output ready);
endinterface

`default_nettype wire

[design/itfp_result_if.sv]
`default_nettype none

interface itfp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] value;
    logic [4:0]  consumed_len;
    logic        char_returned;

    modport source (output valid, output status, output value, output consumed_len,
                    output char_returned, input ready);
    modport sink (input valid, input status, input value, input consumed_len,
                  input char_returned, output ready);
endinterface

`default_nettype wire

[design/itfp_step.sv]
`default_nettype none

module itfp_step #(
    parameter int MAX_FIELD_CHARS = 24
) (
    input  itfp_pkg::t_fstate i_state,
    input  logic [7:0]        i_char,
    input  logic              i_end,
    input  logic [1:0]        i_base_mode,
    input  logic [4:0]        i_max_len,
    output itfp_pkg::t_fstate o_next_state,
    output logic              o_emit,
    output itfp_pkg::t_result o_result
);
    import itfp_pkg::*;

    localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_FIELD_CHARS);

    logic [CNT_W-1:0] lim;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] lead;
    logic [1:0]       eff_base;
    logic [1:0]       base_d;
    logic [4:0]       dv;
    logic [4:0]       radix;
    logic             is_sign;
    logic             is_x;
    logic             take;
    logic             early;
    logic             at_end;
    logic [67:0]      mac;
    t_fstate          upd;
    t_fstate          src;
    t_fstate          cleared;

    always_comb begin
        lim = (i_max_len == 5'd0 || {1'b0, i_max_len} > MaxCnt) ? MaxCnt
                                                               : {1'b0, i_max_len};
        eff_base = (i_state.char_count == '0) ? i_base_mode : i_state.rbase;
        lead     = {{(CNT_W-1){1'b0}}, i_state.sign_taken};
        cnt_inc  = i_state.char_count + CNT_W'(1);
        early    = i_state.char_count >= lim;
        is_sign  = (i_char == CH_PLUS) || (i_char == CH_MINUS);
        is_x     = (i_char == CH_LX) || (i_char == CH_UX);

        dv = 5'd16;
        if (i_char inside {[CH_ZERO:CH_NINE]}) begin
            dv = 5'(i_char - CH_ZERO);
        end else if (i_char inside {[CH_LA:CH_LF]}) begin
            dv = 5'(i_char - CH_LA) + 5'd10;
        end else if (i_char inside {[CH_UA:CH_UF]}) begin
            dv = 5'(i_char - CH_UA) + 5'd10;
        end

        base_d = eff_base;
        if (dv inside {[5'd1:5'd9]} && eff_base == BASE_AUTO) begin
            base_d = i_state.first_zero ? BASE_OCT : BASE_DEC;
        end
        case (base_d)
            BASE_OCT: radix = 5'd8;
            BASE_DEC: radix = 5'd10;
            BASE_HEX: radix = 5'd16;
            default:  radix = 5'd1;
        endcase

        case (base_d)
            BASE_OCT: mac = {4'd0, i_state.acc} << 3;
            BASE_DEC: mac = ({4'd0, i_state.acc} << 3) + ({4'd0, i_state.acc} << 1);
            BASE_HEX: mac = {4'd0, i_state.acc} << 4;
            default:  mac = {4'd0, i_state.acc};
        endcase
        mac = mac + {63'd0, dv};

        upd = i_state;
        upd.rbase = eff_base;
        take = 1'b0;
        if (is_sign) begin
            if (i_state.char_count == '0) begin
                take = 1'b1;
                upd.sign_taken = 1'b1;
                upd.negative = (i_char == CH_MINUS);
            end
        end else if (is_x) begin
            if (eff_base == BASE_AUTO) begin
                upd.rbase = BASE_HEX;
            end
            if (upd.rbase == BASE_HEX && i_state.char_count == lead + CNT_W'(1)
                    && i_state.first_zero) begin
                take = 1'b1;
                upd.prefix_seen = 1'b1;
            end
        end else if (dv < 5'd16) begin
            upd.rbase = base_d;
            if (dv < radix) begin
                take = 1'b1;
                if (i_state.char_count == lead && dv == 5'd0) begin
                    upd.first_zero = 1'b1;
                end
                if (i_state.prefix_seen) begin
                    upd.digit_after = 1'b1;
                end
                if (base_d != BASE_AUTO && !i_state.overflowed) begin
                    if (|mac[67:64]) begin
                        upd.overflowed = 1'b1;
                    end else begin
                        upd.acc = mac[63:0];
                    end
                end
            end
        end
        upd.char_count = cnt_inc;

        cleared = '0;
        cleared.rbase = i_base_mode;

        src = i_state;
        at_end = 1'b0;
        o_result.returned = 1'b0;
        if (early) begin
            o_emit = 1'b1;
            at_end = i_end;
            o_result.returned = !i_end;
        end else if (i_end) begin
            o_emit = 1'b1;
            at_end = 1'b1;
        end else if (!take) begin
            o_emit = 1'b1;
            o_result.returned = 1'b1;
        end else begin
            o_emit = (cnt_inc >= lim);
            src = upd;
        end

        if (src.char_count == '0) begin
            o_result.status = at_end ? ST_INPUT : ST_MATCH;
        end else if (src.char_count == {{(CNT_W-1){1'b0}}, src.sign_taken}) begin
            o_result.status = ST_MATCH;
        end else if (src.prefix_seen && !src.digit_after) begin
            o_result.status = ST_MATCH;
        end else begin
            o_result.status = ST_OK;
        end
        o_result.acc        = src.acc;
        o_result.negative   = src.negative;
        o_result.overflowed = src.overflowed;
        o_result.count      = src.char_count[4:0];

        o_next_state = o_emit ? cleared : upd;
    end

endmodule

`default_nettype wire

[design/integer_text_field_parser_unit.sv]
// Integer field parser: takes one character (or an end-of-input mark) per item and
// returns one result when the field closes: on a rejected character (handed back
// with char_returned set), on end of input, or when the field width is reached.
// One item is accepted every clock cycle while the output is not stalled; the item
// is taken into the input register, and the result of the item that closes the field
// into the result register. A result waiting on a stalled output holds the item
// behind it in the input register, so the input stalls one item later.
// Each step is one constant-radix shift-add on the 64-bit accumulator between the
// input register and the field state. Write configuration only while no field
// is in progress; the base is taken from base_mode at the field's first character.
`default_nettype none

`include "integer_text_field_parser_unit_defines.svh"

module integer_text_field_parser_unit #(
    parameter int MAX_FIELD_CHARS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [4:0]          i_cfg_data,
    itfp_item_if.sink           i_item,
    itfp_result_if.source       o_result
);
    import itfp_pkg::*;

    logic [1:0]  r_base_mode;
    logic [4:0]  r_max_len;
    logic [1:0]  r_value_bytes;

    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_end;

    t_fstate     r_state;
    t_fstate     n_state;
    logic        step_emit;
    t_result     step_res;

    logic        r_out_valid;
    t_result     r_out;
    logic [1:0]  r_out_bytes;

    logic        advance;
    logic [63:0] raw_value;

    assign advance = !r_out_valid || o_result.ready;
    assign i_item.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_mode   <= BASE_DEC;
            r_max_len     <= 5'd24;
            r_value_bytes <= BYTES_4;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE_MODE:   r_base_mode   <= i_cfg_data[1:0];
                CFG_MAX_LEN:     r_max_len     <= i_cfg_data;
                CFG_VALUE_BYTES: r_value_bytes <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // hold the item while the step stage is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in_char <= i_item.char_code;
            r_in_end  <= i_item.input_ended;
        end
    end

    itfp_step #(
        .MAX_FIELD_CHARS(MAX_FIELD_CHARS)
    ) u_step (
        .i_state      (r_state),
        .i_char       (r_in_char),
        .i_end        (r_in_end),
        .i_base_mode  (r_base_mode),
        .i_max_len    (r_max_len),
        .o_next_state (n_state),
        .o_emit       (step_emit),
        .o_result     (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= '{rbase: BASE_DEC, default: '0};
            r_out_valid   <= 1'b0;
        end else if (advance) begin
            if (r_in_valid) begin
                r_state <= n_state;
            end
            r_out_valid <= r_in_valid && step_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && step_emit) begin
            r_out       <= step_res;
            r_out_bytes <= r_value_bytes;
        end
    end

    always_comb begin
        if (r_out.overflowed) begin
            raw_value = '1;
        end else if (r_out.negative) begin
            raw_value = 64'd0 - r_out.acc;
        end else begin
            raw_value = r_out.acc;
        end
        case (r_out_bytes)
            BYTES_1: raw_value = {56'd0, raw_value[7:0]};
            BYTES_2: raw_value = {48'd0, raw_value[15:0]};
            BYTES_4: raw_value = {32'd0, raw_value[31:0]};
            default: ;
        endcase
        if (r_out.status != ST_OK) begin
            raw_value = '0;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.status        = r_out.status;
    assign o_result.value         = raw_value;
    assign o_result.consumed_len  = r_out.count;
    assign o_result.char_returned = r_out.returned;

    `ITFP_ASSERT(a_count_bound, r_state.char_count <= CNT_W'(MAX_FIELD_CHARS))
    `ITFP_ASSERT_NEXT(a_clear_after_result, advance && r_in_valid && step_emit,
        r_state.char_count == '0)
    `ITFP_ASSERT(a_ready_when_drained, o_result.ready |-> i_item.ready)
    `ITFP_ASSERT(a_input_err_empty,
        (r_out_valid && r_out.status == ST_INPUT) |-> (r_out.count == 5'd0))
    `ITFP_ASSERT(a_return_empty_match,
        (r_out_valid && r_out.returned && r_out.count == 5'd0) |-> (r_out.status == ST_MATCH))

endmodule

`default_nettype wire

[test/tb_top.sv]
module tb_top;
    import itfp_pkg::*;

    localparam int          MAX_CHARS   = 24;
    localparam int          STALL_LIMIT = 2000;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] value;
        logic [4:0]  len;
        logic        returned;
    } t_parse_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [4:0] i_cfg_data;

    itfp_item_if   item_ch ();
    itfp_result_if res_ch ();

    integer_text_field_parser_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_ch),
        .o_result   (res_ch)
    );

    logic [1:0]    cfg_base  = BASE_DEC;
    logic [4:0]    cfg_len   = 5'd24;
    logic [1:0]    cfg_bytes = BYTES_4;

    int            char_cnt    = 0;
    logic          sign_taken  = 1'b0;
    logic          negative    = 1'b0;
    logic          first_zero  = 1'b0;
    logic [1:0]    rbase       = BASE_DEC;
    logic          prefix_seen = 1'b0;
    logic          digit_after = 1'b0;
    logic [63:0]   acc         = '0;
    logic          overflowed  = 1'b0;

    t_parse_result parsed_fields_q[$];
    int            mismatch_count = 0;
    int            items_sent     = 0;
    int            stall_cycles   = 0;
    int            src_idle_pct   = 0;
    int            snk_idle_pct   = 0;

    always #5 i_clk = ~i_clk;

    function automatic void close_field(input logic at_end, input logic returned);
        t_parse_result r;
        r.status = ST_OK;
        r.value  = '0;
        if (char_cnt == 0) begin
            r.status = at_end ? ST_INPUT : ST_MATCH;
        end else if (char_cnt == (sign_taken ? 1 : 0)) begin
            r.status = ST_MATCH;
        end else if (prefix_seen && !digit_after) begin
            r.status = ST_MATCH;
        end
        if (r.status == ST_OK) begin
            r.value = overflowed ? ALL_ONES : (negative ? 64'd0 - acc : acc);
            case (cfg_bytes)
                BYTES_1: r.value &= 64'hFF;
                BYTES_2: r.value &= 64'hFFFF;
                BYTES_4: r.value &= 64'hFFFF_FFFF;
                default: ;
            endcase
        end
        r.len      = 5'(char_cnt);
        r.returned = returned;
        parsed_fields_q.push_back(r);
        char_cnt    = 0;
        sign_taken  = 1'b0;
        negative    = 1'b0;
        first_zero  = 1'b0;
        rbase       = cfg_base;
        prefix_seen = 1'b0;
        digit_after = 1'b0;
        acc         = '0;
        overflowed  = 1'b0;
    endfunction

    function automatic void parse_char(input logic [7:0] c, input logic ended);
        int          lim;
        int          lead;
        int          dv;
        logic        take;
        logic [63:0] radix;
        lim  = cfg_len;
        lead = sign_taken ? 1 : 0;
        dv   = 16;
        take = 1'b0;
        if (lim == 0 || lim > MAX_CHARS) lim = MAX_CHARS;
        if (char_cnt == 0) rbase = cfg_base;
        if (char_cnt >= lim) begin
            close_field(ended, !ended);
            return;
        end
        if (ended) begin
            close_field(1'b1, 1'b0);
            return;
        end
        if (c >= CH_ZERO && c <= CH_NINE) dv = c - CH_ZERO;
        else if (c >= CH_LA && c <= CH_LF) dv = c - CH_LA + 10;
        else if (c >= CH_UA && c <= CH_UF) dv = c - CH_UA + 10;

        if (c == CH_PLUS || c == CH_MINUS) begin
            if (char_cnt == 0) begin
                take       = 1'b1;
                sign_taken = 1'b1;
                negative   = (c == CH_MINUS);
            end
        end else if (c == CH_LX || c == CH_UX) begin
            if (rbase == BASE_AUTO) rbase = BASE_HEX;
            if (rbase == BASE_HEX && char_cnt == lead + 1 && first_zero) begin
                take        = 1'b1;
                prefix_seen = 1'b1;
            end
        end else if (dv < 16) begin
            if (dv >= 1 && dv <= 9 && rbase == BASE_AUTO) begin
                rbase = first_zero ? BASE_OCT : BASE_DEC;
            end
            case (rbase)
                BASE_OCT: radix = 64'd8;
                BASE_DEC: radix = 64'd10;
                BASE_HEX: radix = 64'd16;
                default:  radix = 64'd1;
            endcase
            if (64'(dv) < radix) begin
                take = 1'b1;
                if (char_cnt == lead && dv == 0) first_zero = 1'b1;
                if (prefix_seen) digit_after = 1'b1;
                if (rbase != BASE_AUTO && !overflowed) begin
                    if (acc > (ALL_ONES - 64'(dv)) / radix) overflowed = 1'b1;
                    else acc = acc * radix + 64'(dv);
                end
            end
        end

        if (!take) begin
            close_field(1'b0, 1'b1);
            return;
        end
        char_cnt++;
        if (char_cnt >= lim) close_field(1'b0, 1'b0);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < 100) begin
            $display("mismatch in %s: got %0h, expected %0h", what, got, want);
        end
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_parse_result want;
        if (i_rst_n) begin
            if (item_ch.valid && item_ch.ready) begin
                parse_char(item_ch.char_code, item_ch.input_ended);
            end
            if (res_ch.valid && res_ch.ready) begin
                if (parsed_fields_q.size() == 0) begin
                    report_mismatch("unexpected result status", 64'(res_ch.status), '0);
                end else begin
                    want = parsed_fields_q.pop_front();
                    if (res_ch.status !== want.status)
                        report_mismatch("status", 64'(res_ch.status), 64'(want.status));
                    if (res_ch.value !== want.value)
                        report_mismatch("value", res_ch.value, want.value);
                    if (res_ch.consumed_len !== want.len)
                        report_mismatch("consumed_len", 64'(res_ch.consumed_len),
                                        64'(want.len));
                    if (res_ch.char_returned !== want.returned)
                        report_mismatch("char_returned", 64'(res_ch.char_returned),
                                        64'(want.returned));
                end
            end
        end
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    task automatic send_item(input logic [7:0] c, input logic ended);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.char_code   <= c;
        item_ch.input_ended <= ended;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s, input logic end_mark);
        for (int k = 0; k < s.len(); k++) send_item(s[k], 1'b0);
        if (end_mark) send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // close any open field and drain results so the registers can change
    task automatic wait_idle();
        if (char_cnt != 0) send_item(8'($urandom_range(0, 255)), 1'b1);
        item_ch.valid <= 1'b0;
        while (parsed_fields_q.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [1:0] base, input logic [4:0] len,
                              input logic [1:0] bytes);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BASE_MODE;
        i_cfg_data  <= {3'b000, base};
        @(negedge i_clk);
        i_cfg_index <= CFG_MAX_LEN;
        i_cfg_data  <= len;
        @(negedge i_clk);
        i_cfg_index <= CFG_VALUE_BYTES;
        i_cfg_data  <= {3'b000, bytes};
        @(negedge i_clk);
        i_cfg_we  <= 1'b0;
        cfg_base  = base;
        cfg_len   = len;
        cfg_bytes = bytes;
    endtask

    task automatic send_random_field();
        logic [1:0] style;
        int         radix;
        int         ndig;
        int         d;
        int         term;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            return;
        end
        style = cfg_base;
        if ($urandom_range(0, 1)) send_item($urandom_range(0, 1) ? CH_MINUS : CH_PLUS, 1'b0);
        if ((style == BASE_HEX || style == BASE_AUTO) && $urandom_range(0, 2) == 0) begin
            send_item(CH_ZERO, 1'b0);
            send_item($urandom_range(0, 1) ? CH_LX : CH_UX, 1'b0);
            style = BASE_HEX;
        end else if (style == BASE_AUTO) begin
            if ($urandom_range(0, 1)) begin
                send_item(CH_ZERO, 1'b0);
                style = BASE_OCT;
            end else begin
                style = BASE_DEC;
            end
        end
        radix = (style == BASE_OCT) ? 8 : (style == BASE_HEX) ? 16 : 10;
        ndig  = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 8);
        for (int k = 0; k < ndig; k++) begin
            d = $urandom_range(0, radix - 1);
            if (d < 10) send_item(CH_ZERO + 8'(d), 1'b0);
            else send_item(($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(d - 10), 1'b0);
        end
        term = $urandom_range(0, 9);
        if (term < 3) send_item(8'($urandom_range(0, 255)), 1'b1);
        else if (term < 8) send_item(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic test_sign_and_decimal();
        send_text("+123", 1'b1);
        send_text("-1 ", 1'b0);
    endtask

    task automatic test_empty_and_rejected();
        send_item(8'h00, 1'b1);
        send_text("-a", 1'b0);
        send_text("z", 1'b0);
    endtask

    task automatic test_base_prefix();
        set_config(BASE_AUTO, 5'd24, BYTES_8);
        send_text("0x1F", 1'b1);
        send_text("0Xg", 1'b0);
        send_text("017", 1'b1);
    endtask

    task automatic test_width_limit();
        set_config(BASE_DEC, 5'd1, BYTES_8);
        send_text("7", 1'b0);
    endtask

    task automatic test_random_fields(input int src_pct, input int snk_pct, input int first);
        int start;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int p = 0; p < 4; p++) begin
            case (first + p)
                0:  set_config(BASE_AUTO, 5'd24, BYTES_8);
                1:  set_config(BASE_OCT,  5'd5,  BYTES_1);
                2:  set_config(BASE_DEC,  5'd0,  BYTES_2);
                3:  set_config(BASE_HEX,  5'd31, BYTES_8);
                4:  set_config(BASE_AUTO, 5'd1,  BYTES_4);
                5:  set_config(BASE_HEX,  5'd17, BYTES_8);
                6:  set_config(BASE_DEC,  5'd24, BYTES_8);
                7:  set_config(BASE_OCT,  5'd24, BYTES_8);
                8:  set_config(BASE_AUTO, 5'd12, BYTES_8);
                9:  set_config(BASE_HEX,  5'd24, BYTES_1);
                10: set_config(BASE_DEC,  5'd20, BYTES_4);
                default: set_config(BASE_AUTO, 5'd2, BYTES_2);
            endcase
            start = items_sent;
            while (items_sent - start < 48) send_random_field();
        end
    endtask

    initial begin
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_index         = CFG_BASE_MODE;
        i_cfg_data          = '0;
        item_ch.valid       = 1'b0;
        item_ch.char_code   = '0;
        item_ch.input_ended = 1'b0;
        res_ch.ready        = 1'b0;
        src_idle_pct        = 19;
        snk_idle_pct        = 57;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_sign_and_decimal();
        test_empty_and_rejected();
        test_base_prefix();
        test_width_limit();
        test_random_fields(19, 57, 0);
        test_random_fields(57, 19, 4);
        test_random_fields(0, 0, 8);

        wait_idle();
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
